// File: sv/uart_image_frame_receiver_core_macros.svh
// ----------------------------------------------------------------------------
// uart_image_frame_receiver_core_macros.svh
// Assertion helpers shared by the frame receiver checkers.
// ----------------------------------------------------------------------------
`ifndef UART_IMAGE_FRAME_RECEIVER_CORE_MACROS_SVH
`define UART_IMAGE_FRAME_RECEIVER_CORE_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define UIFR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen.
`define UIFR_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    `UIFR_ASSERT(label, clk, rst_n, !(cond), msg)

`endif

// File: sv/uifr_pkg.sv
// ----------------------------------------------------------------------------
// uifr_pkg
// Types, codes and the CRC-32 byte step for the image frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package uifr_pkg;

    localparam int unsigned CHUNK_BYTES = 256;
    localparam logic [31:0] IMAGE_WORD_EXPECTED = 32'h96f3_b83d;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_TICK  = 2'd1,
        OP_START = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_NONE            = 4'd0,
        ST_READY           = 4'd1,
        ST_GO              = 4'd2,
        ST_OK              = 4'd3,
        ST_BAD_MAGIC       = 4'd4,
        ST_BAD_TYPE        = 4'd5,
        ST_BAD_LENGTH      = 4'd6,
        ST_BAD_CRC         = 4'd7,
        ST_PAYLOAD_TIMEOUT = 4'd8,
        ST_BAD_IMAGE       = 4'd9,
        ST_HEADER_TIMEOUT  = 4'd10
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_HEADER_MAGIC    = 3'd0,
        REG_IMAGE_TYPE      = 3'd1,
        REG_HEADER_IDLE_MS  = 3'd2,
        REG_PAYLOAD_IDLE_MS = 3'd3,
        REG_HEADER_TOTAL_MS = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic [31:0] header_magic;
        logic [7:0]  image_type;
        logic [15:0] header_idle_ms;
        logic [15:0] payload_idle_ms;
        logic [31:0] header_total_ms;
    } cfg_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic        payload_last;
    } result_t;

    // Reflected CRC-32, one byte, with inversion on entry and exit.
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = ~crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return ~c;
    endfunction

endpackage

`default_nettype wire

// File: sv/uifr_cfg.sv
// ----------------------------------------------------------------------------
// uifr_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module uifr_cfg (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [uifr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [uifr_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output uifr_pkg::cfg_t                           cfg
);

    uifr_pkg::cfg_t cfg_reg;
    uifr_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                uifr_pkg::REG_HEADER_MAGIC:    cfg_next.header_magic = cfg_wdata;
                uifr_pkg::REG_IMAGE_TYPE:      cfg_next.image_type = cfg_wdata[7:0];
                uifr_pkg::REG_HEADER_IDLE_MS:  cfg_next.header_idle_ms = cfg_wdata[15:0];
                uifr_pkg::REG_PAYLOAD_IDLE_MS: cfg_next.payload_idle_ms = cfg_wdata[15:0];
                uifr_pkg::REG_HEADER_TOTAL_MS: cfg_next.header_total_ms = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_magic    <= 32'd0;
            cfg_reg.image_type      <= 8'd1;
            cfg_reg.header_idle_ms  <= 16'd1000;
            cfg_reg.payload_idle_ms <= 16'd10000;
            cfg_reg.header_total_ms <= 32'd30000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: sv/uifr_engine.sv
// ----------------------------------------------------------------------------
// uifr_engine
// Session state and per-item decode: header capture, payload CRC, timeouts.
// ----------------------------------------------------------------------------
`default_nettype none

module uifr_engine (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step,
    input  wire logic [1:0]      op,
    input  wire logic [7:0]      rx_byte,
    input  wire uifr_pkg::cfg_t  cfg,
    output uifr_pkg::result_t    result
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_PAYLOAD
    } phase_t;

    localparam logic [31:0] CHUNK32 = 32'(uifr_pkg::CHUNK_BYTES);

    phase_t      phase_reg, phase_next;
    logic [3:0]  header_index_reg, header_index_next;
    logic [31:0] magic_seen_reg, magic_seen_next;
    logic [7:0]  type_seen_reg, type_seen_next;
    logic [31:0] frame_length_reg, frame_length_next;
    logic [31:0] frame_crc_reg, frame_crc_next;
    logic [31:0] bytes_received_reg, bytes_received_next;
    logic [31:0] running_crc_reg, running_crc_next;
    logic [31:0] image_word_reg, image_word_next;
    logic [15:0] idle_count_reg, idle_count_next;
    logic [31:0] header_elapsed_reg, header_elapsed_next;

    logic [31:0] first_chunk;
    logic [31:0] bytes_inc;
    logic [31:0] crc_step;
    logic [31:0] word_acc;
    logic [31:0] elapsed_inc;
    logic [31:0] magic_acc;
    logic [7:0]  type_acc;
    logic [31:0] length_acc;
    logic [31:0] crc_acc;
    logic [4:0]  hsel;
    logic [4:0]  wsel;

    always_comb
    begin
        phase_next          = phase_reg;
        header_index_next   = header_index_reg;
        magic_seen_next     = magic_seen_reg;
        type_seen_next      = type_seen_reg;
        frame_length_next   = frame_length_reg;
        frame_crc_next      = frame_crc_reg;
        bytes_received_next = bytes_received_reg;
        running_crc_next    = running_crc_reg;
        image_word_next     = image_word_reg;
        idle_count_next     = idle_count_reg;
        header_elapsed_next = header_elapsed_reg;

        result.status        = uifr_pkg::ST_NONE;
        result.payload_byte  = 8'd0;
        result.payload_valid = 1'b0;
        result.payload_last  = 1'b0;

        first_chunk = (frame_length_reg < CHUNK32) ? frame_length_reg : CHUNK32;
        bytes_inc   = bytes_received_reg + 32'd1;
        crc_step    = uifr_pkg::crc32_byte(running_crc_reg, rx_byte);

        wsel     = {bytes_received_reg[1:0], 3'b000};
        word_acc = image_word_reg;
        if (bytes_received_reg < 32'd4)
        begin
            word_acc[wsel +: 8] = image_word_reg[wsel +: 8] | rx_byte;
        end

        elapsed_inc = (header_elapsed_reg != '1) ? header_elapsed_reg + 32'd1
                                                 : header_elapsed_reg;

        // header fields are OR-ed in little-endian order
        hsel       = {header_index_reg[1:0], 3'b000};
        magic_acc  = magic_seen_reg;
        type_acc   = type_seen_reg;
        length_acc = frame_length_reg;
        crc_acc    = frame_crc_reg;
        if (header_index_reg < 4'd4)
        begin
            magic_acc[hsel +: 8] = magic_seen_reg[hsel +: 8] | rx_byte;
        end
        else if (header_index_reg == 4'd4)
        begin
            type_acc = rx_byte;
        end
        else if (header_index_reg >= 4'd8 && header_index_reg < 4'd12)
        begin
            length_acc[hsel +: 8] = frame_length_reg[hsel +: 8] | rx_byte;
        end
        else if (header_index_reg >= 4'd12)
        begin
            crc_acc[hsel +: 8] = frame_crc_reg[hsel +: 8] | rx_byte;
        end

        if (step)
        begin
            unique case (op)
                uifr_pkg::OP_START:
                begin
                    phase_next          = PH_HEADER;
                    header_index_next   = 4'd0;
                    magic_seen_next     = 32'd0;
                    type_seen_next      = 8'd0;
                    frame_length_next   = 32'd0;
                    frame_crc_next      = 32'd0;
                    idle_count_next     = 16'd0;
                    header_elapsed_next = 32'd0;
                    result.status       = uifr_pkg::ST_READY;
                end
                uifr_pkg::OP_BYTE:
                begin
                    if (phase_reg == PH_HEADER)
                    begin
                        idle_count_next   = 16'd0;
                        magic_seen_next   = magic_acc;
                        type_seen_next    = type_acc;
                        frame_length_next = length_acc;
                        frame_crc_next    = crc_acc;
                        if (header_index_reg != 4'd15)
                        begin
                            header_index_next = header_index_reg + 4'd1;
                        end
                        else
                        begin
                            header_index_next = 4'd0;
                            phase_next        = PH_IDLE;
                            if (magic_acc != cfg.header_magic)
                            begin
                                result.status = uifr_pkg::ST_BAD_MAGIC;
                            end
                            else if (type_acc != cfg.image_type)
                            begin
                                result.status = uifr_pkg::ST_BAD_TYPE;
                            end
                            else if (length_acc == 32'd0)
                            begin
                                result.status = uifr_pkg::ST_BAD_LENGTH;
                            end
                            else
                            begin
                                phase_next          = PH_PAYLOAD;
                                bytes_received_next = 32'd0;
                                running_crc_next    = 32'd0;
                                image_word_next     = 32'd0;
                                result.status       = uifr_pkg::ST_GO;
                            end
                        end
                    end
                    else if (phase_reg == PH_PAYLOAD)
                    begin
                        idle_count_next     = 16'd0;
                        image_word_next     = word_acc;
                        bytes_received_next = bytes_inc;
                        running_crc_next    = crc_step;
                        if (bytes_inc == first_chunk && first_chunk >= 32'd4 &&
                            word_acc != uifr_pkg::IMAGE_WORD_EXPECTED)
                        begin
                            result.status = uifr_pkg::ST_BAD_IMAGE;
                            phase_next    = PH_IDLE;
                        end
                        else
                        begin
                            result.payload_byte  = rx_byte;
                            result.payload_valid = 1'b1;
                            if (bytes_inc >= frame_length_reg)
                            begin
                                result.payload_last = 1'b1;
                                result.status = (crc_step == frame_crc_reg) ?
                                                uifr_pkg::ST_OK : uifr_pkg::ST_BAD_CRC;
                                phase_next = PH_IDLE;
                            end
                        end
                    end
                end
                uifr_pkg::OP_TICK:
                begin
                    if (phase_reg == PH_HEADER)
                    begin
                        header_elapsed_next = elapsed_inc;
                        if (idle_count_reg >= cfg.header_idle_ms)
                        begin
                            if (elapsed_inc >= cfg.header_total_ms)
                            begin
                                result.status   = uifr_pkg::ST_HEADER_TIMEOUT;
                                phase_next      = PH_IDLE;
                                idle_count_next = 16'd0;
                            end
                            else
                            begin
                                // re-prompt and restart the header, keep total time
                                phase_next        = PH_HEADER;
                                header_index_next = 4'd0;
                                magic_seen_next   = 32'd0;
                                type_seen_next    = 8'd0;
                                frame_length_next = 32'd0;
                                frame_crc_next    = 32'd0;
                                idle_count_next   = 16'd0;
                                result.status     = uifr_pkg::ST_READY;
                            end
                        end
                        else
                        begin
                            idle_count_next = idle_count_reg + 16'd1;
                        end
                    end
                    else if (phase_reg == PH_PAYLOAD)
                    begin
                        if (idle_count_reg >= cfg.payload_idle_ms)
                        begin
                            result.status   = uifr_pkg::ST_PAYLOAD_TIMEOUT;
                            phase_next      = PH_IDLE;
                            idle_count_next = 16'd0;
                        end
                        else
                        begin
                            idle_count_next = idle_count_reg + 16'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            header_index_reg   <= 4'd0;
            magic_seen_reg     <= 32'd0;
            type_seen_reg      <= 8'd0;
            frame_length_reg   <= 32'd0;
            frame_crc_reg      <= 32'd0;
            bytes_received_reg <= 32'd0;
            running_crc_reg    <= 32'd0;
            image_word_reg     <= 32'd0;
            idle_count_reg     <= 16'd0;
            header_elapsed_reg <= 32'd0;
        end
        else
        begin
            phase_reg          <= phase_next;
            header_index_reg   <= header_index_next;
            magic_seen_reg     <= magic_seen_next;
            type_seen_reg      <= type_seen_next;
            frame_length_reg   <= frame_length_next;
            frame_crc_reg      <= frame_crc_next;
            bytes_received_reg <= bytes_received_next;
            running_crc_reg    <= running_crc_next;
            image_word_reg     <= image_word_next;
            idle_count_reg     <= idle_count_next;
            header_elapsed_reg <= header_elapsed_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/uart_image_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// uart_image_frame_receiver_core
// Length-prefixed update frame receiver with CRC-32 check.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): operation plus rx_byte; one transaction
//   per UART byte, per 1 ms tick, or per session start.
//   Output channel (out_valid/out_ready): exactly one result transaction per
//   input transaction, in order: status, payload_byte, payload_valid,
//   payload_last.
//   Config port (cfg_we/cfg_index/cfg_wdata): single-cycle writes, only
//   while no transaction is in flight.
//   Datapath: an accepted input is held in the input register, and its result
//   is then captured in the result register.
//   Throughput: one transaction per cycle unless out_ready stalls; the CRC byte
//   step and header checks sit in the single stage between the two registers.
//   Reset: registers return to their defaults, the session goes idle and
//   both pipeline registers are emptied.
//   Stall: while out_ready is low the result register holds; one more
//   input is held in the input register, then in_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_image_frame_receiver_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output      logic                              in_ready,
    input  wire logic [1:0]                        operation,
    input  wire logic [7:0]                        rx_byte,
    output      logic                              out_valid,
    input  wire logic                              out_ready,
    output      logic [3:0]                        status,
    output      logic [7:0]                        payload_byte,
    output      logic                              payload_valid,
    output      logic                              payload_last,
    input  wire logic                              cfg_we,
    input  wire logic [uifr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [uifr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    uifr_pkg::cfg_t    cfg;
    uifr_pkg::result_t result;
    uifr_pkg::result_t result_reg;

    logic       in_valid_reg, in_valid_next;
    logic [1:0] op_reg;
    logic [7:0] byte_reg;
    logic       out_valid_reg, out_valid_next;
    logic       advance;
    logic       in_take;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg   <= operation;
            byte_reg <= rx_byte;
        end
        if (advance)
        begin
            result_reg <= result;
        end
    end

    uifr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    uifr_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .op      (op_reg),
        .rx_byte (byte_reg),
        .cfg     (cfg),
        .result  (result)
    );

    assign out_valid     = out_valid_reg;
    assign status        = result_reg.status;
    assign payload_byte  = result_reg.payload_byte;
    assign payload_valid = result_reg.payload_valid;
    assign payload_last  = result_reg.payload_last;

endmodule

`default_nettype wire

// File: sv/uifr_checker.sv
// ----------------------------------------------------------------------------
// uifr_checker
// Port-level checks on the frame receiver result channel.
// ----------------------------------------------------------------------------
`default_nettype none

`include "uart_image_frame_receiver_core_macros.svh"

module uifr_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [3:0] status,
    input wire logic [7:0] payload_byte,
    input wire logic       payload_valid,
    input wire logic       payload_last
);

    `UIFR_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(status) && $stable(payload_byte), "result changed while stalled")
    `UIFR_ASSERT_NEVER(a_last_needs_valid, clk, rst_n, out_valid && payload_last && !payload_valid, "payload_last without payload_valid")
    `UIFR_ASSERT_NEVER(a_idle_byte_zero, clk, rst_n, out_valid && !payload_valid && (payload_byte != 8'd0), "payload_byte nonzero without payload_valid")
    `UIFR_ASSERT(a_last_status, clk, rst_n, out_valid && payload_last |-> (status == uifr_pkg::ST_OK) || (status == uifr_pkg::ST_BAD_CRC), "final byte without crc verdict")
    `UIFR_ASSERT(a_mid_status, clk, rst_n, out_valid && payload_valid && !payload_last |-> status == uifr_pkg::ST_NONE, "status on a mid-frame byte")

endmodule

bind uart_image_frame_receiver_core uifr_checker u_uifr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .payload_byte  (payload_byte),
    .payload_valid (payload_valid),
    .payload_last  (payload_last)
);

`default_nettype wire

// File: sim/tb_uart_image_frame_receiver_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_uart_image_frame_receiver_core
// Self-checking bench for the UART update frame receiver.
// ----------------------------------------------------------------------------
// A short table of transactions walks the idle, header and payload paths from
// reset. Then each settings phase plays well-formed frames with random
// content, corrupted headers, bad images, bad CRCs, idle stalls, restarts and
// noise. Every accepted transaction is run through a local frame predictor
// and every result transaction is compared with the oldest prediction.
// ----------------------------------------------------------------------------

module tb_uart_image_frame_receiver_core;

    localparam int ITEM_TARGET = 1450;
    localparam int PHASES = 4;
    localparam int SETTLE_CYCLES = 4;

    typedef enum logic [1:0] {
        SESS_IDLE,
        SESS_HEADER,
        SESS_PAYLOAD
    } session_t;

    typedef enum int {
        FR_GOOD,
        FR_BAD_MAGIC,
        FR_BAD_TYPE,
        FR_ZERO_LEN,
        FR_BAD_IMAGE,
        FR_BAD_CRC,
        FR_HEADER_STALL,
        FR_PAYLOAD_STALL,
        FR_RESTART,
        FR_NOISE
    } frame_kind_t;

    typedef enum int {
        DRAIN_FREE,
        DRAIN_SPARSE,
        DRAIN_PATTERN,
        DRAIN_COIN
    } drain_mode_t;

    typedef struct packed {
        uifr_pkg::op_t     op;
        logic [7:0]        data;
        logic              typed;
        uifr_pkg::status_t want;
    } stim_row_t;

    // Reset settings: magic 0, type 1, so this header is accepted as is.
    localparam stim_row_t DIRECTED_ROWS [25] = '{
        '{uifr_pkg::OP_BYTE,  8'hFF, 1'b1, uifr_pkg::ST_NONE},
        '{uifr_pkg::OP_TICK,  8'h00, 1'b1, uifr_pkg::ST_NONE},
        '{uifr_pkg::OP_NONE,  8'hA5, 1'b1, uifr_pkg::ST_NONE},
        '{uifr_pkg::OP_START, 8'h00, 1'b1, uifr_pkg::ST_READY},
        '{uifr_pkg::OP_BYTE,  8'h00, 1'b1, uifr_pkg::ST_NONE},
        '{uifr_pkg::OP_BYTE,  8'h00, 1'b1, uifr_pkg::ST_NONE},
        '{uifr_pkg::OP_BYTE,  8'h00, 1'b1, uifr_pkg::ST_NONE},
        '{uifr_pkg::OP_BYTE,  8'h00, 1'b1, uifr_pkg::ST_NONE},
        '{uifr_pkg::OP_BYTE,  8'h01, 1'b1, uifr_pkg::ST_NONE},
        '{uifr_pkg::OP_BYTE,  8'hFF, 1'b1, uifr_pkg::ST_NONE},
        '{uifr_pkg::OP_BYTE,  8'h00, 1'b1, uifr_pkg::ST_NONE},
        '{uifr_pkg::OP_BYTE,  8'hFF, 1'b1, uifr_pkg::ST_NONE},
        '{uifr_pkg::OP_BYTE,  8'h04, 1'b1, uifr_pkg::ST_NONE},
        '{uifr_pkg::OP_BYTE,  8'h00, 1'b1, uifr_pkg::ST_NONE},
        '{uifr_pkg::OP_BYTE,  8'h00, 1'b1, uifr_pkg::ST_NONE},
        '{uifr_pkg::OP_BYTE,  8'h00, 1'b1, uifr_pkg::ST_NONE},
        '{uifr_pkg::OP_BYTE,  8'h00, 1'b1, uifr_pkg::ST_NONE},
        '{uifr_pkg::OP_BYTE,  8'hFF, 1'b1, uifr_pkg::ST_NONE},
        '{uifr_pkg::OP_BYTE,  8'h00, 1'b1, uifr_pkg::ST_NONE},
        '{uifr_pkg::OP_BYTE,  8'hFF, 1'b1, uifr_pkg::ST_GO},
        '{uifr_pkg::OP_BYTE,  8'h3D, 1'b0, uifr_pkg::ST_NONE},
        '{uifr_pkg::OP_BYTE,  8'hB8, 1'b0, uifr_pkg::ST_NONE},
        '{uifr_pkg::OP_BYTE,  8'hF3, 1'b0, uifr_pkg::ST_NONE},
        '{uifr_pkg::OP_BYTE,  8'h96, 1'b0, uifr_pkg::ST_NONE},
        '{uifr_pkg::OP_NONE,  8'hFF, 1'b1, uifr_pkg::ST_NONE}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  operation;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [3:0]  status;
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        payload_last;
    logic        cfg_we;
    logic [uifr_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [uifr_pkg::CFG_DATA_W-1:0]  cfg_wdata;

    // Typed expectation that rides along with the current transaction
    logic              row_typed;
    uifr_pkg::status_t row_want;

    // Predictor state
    uifr_pkg::cfg_t model_cfg;
    session_t    session;
    logic [3:0]  hdr_pos;
    logic [31:0] seen_magic;
    logic [7:0]  seen_type;
    logic [31:0] want_len;
    logic [31:0] want_crc;
    logic [31:0] payload_count;
    logic [31:0] crc_state;
    logic [31:0] first_word;
    logic [15:0] idle_ticks;
    logic [31:0] header_ticks;

    uifr_pkg::result_t expected_results [$];
    int          mismatch_count = 0;
    int          items_done = 0;
    int          burst_left = 0;
    int          stall_count = 0;
    drain_mode_t drain_mode = DRAIN_FREE;

    uart_image_frame_receiver_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .payload_byte  (payload_byte),
        .payload_valid (payload_valid),
        .payload_last  (payload_last),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always #2 clk = ~clk;

    // CRC-32 register update, reflected, without the inversions
    function automatic logic [31:0] crc_step(input logic [31:0] acc, input logic [7:0] d);
        logic [31:0] c;
        int          i;
        c = acc;
        for (i = 0; i < 8; i++)
        begin
            c = {1'b0, c[31:1]} ^ ((c[0] ^ d[i]) ? uifr_pkg::CRC_POLY : 32'd0);
        end
        return c;
    endfunction

    function automatic void open_header();
        session = SESS_HEADER;
        hdr_pos = 4'd0;
        seen_magic = 32'd0;
        seen_type = 8'd0;
        want_len = 32'd0;
        want_crc = 32'd0;
        idle_ticks = 16'd0;
    endfunction

    function automatic uifr_pkg::result_t predict_frame_result(input uifr_pkg::op_t op,
                                                               input logic [7:0] b);
        uifr_pkg::result_t r;
        logic [31:0]       chunk_end;
        r = '0;
        r.status = uifr_pkg::ST_NONE;
        case (op)
            uifr_pkg::OP_START:
            begin
                open_header();
                header_ticks = 32'd0;
                r.status = uifr_pkg::ST_READY;
            end
            uifr_pkg::OP_BYTE:
            begin
                if (session == SESS_HEADER)
                begin
                    idle_ticks = 16'd0;
                    if (hdr_pos < 4'd4)
                        seen_magic |= {24'd0, b} << (8 * hdr_pos[1:0]);
                    else if (hdr_pos == 4'd4)
                        seen_type = b;
                    else if (hdr_pos >= 4'd8 && hdr_pos < 4'd12)
                        want_len |= {24'd0, b} << (8 * hdr_pos[1:0]);
                    else if (hdr_pos >= 4'd12)
                        want_crc |= {24'd0, b} << (8 * hdr_pos[1:0]);
                    if (hdr_pos < 4'd15)
                    begin
                        hdr_pos++;
                    end
                    else
                    begin
                        hdr_pos = 4'd0;
                        session = SESS_IDLE;
                        if (seen_magic != model_cfg.header_magic)
                            r.status = uifr_pkg::ST_BAD_MAGIC;
                        else if (seen_type != model_cfg.image_type)
                            r.status = uifr_pkg::ST_BAD_TYPE;
                        else if (want_len == 32'd0)
                            r.status = uifr_pkg::ST_BAD_LENGTH;
                        else
                        begin
                            session = SESS_PAYLOAD;
                            payload_count = 32'd0;
                            crc_state = '1;
                            first_word = 32'd0;
                            r.status = uifr_pkg::ST_GO;
                        end
                    end
                end
                else if (session == SESS_PAYLOAD)
                begin
                    chunk_end = (want_len < uifr_pkg::CHUNK_BYTES) ? want_len
                                                                   : uifr_pkg::CHUNK_BYTES;
                    idle_ticks = 16'd0;
                    if (payload_count < 32'd4)
                        first_word |= {24'd0, b} << (8 * payload_count[1:0]);
                    payload_count++;
                    crc_state = crc_step(crc_state, b);
                    // image word is judged on the byte that closes the first chunk
                    if (payload_count == chunk_end && chunk_end >= 32'd4 &&
                        first_word != uifr_pkg::IMAGE_WORD_EXPECTED)
                    begin
                        r.status = uifr_pkg::ST_BAD_IMAGE;
                        session = SESS_IDLE;
                    end
                    else
                    begin
                        r.payload_byte = b;
                        r.payload_valid = 1'b1;
                        if (payload_count >= want_len)
                        begin
                            r.payload_last = 1'b1;
                            r.status = (~crc_state == want_crc) ? uifr_pkg::ST_OK
                                                                : uifr_pkg::ST_BAD_CRC;
                            session = SESS_IDLE;
                        end
                    end
                end
            end
            uifr_pkg::OP_TICK:
            begin
                if (session == SESS_HEADER)
                begin
                    if (header_ticks != '1)
                        header_ticks++;
                    if (idle_ticks >= model_cfg.header_idle_ms)
                    begin
                        if (header_ticks >= model_cfg.header_total_ms)
                        begin
                            r.status = uifr_pkg::ST_HEADER_TIMEOUT;
                            session = SESS_IDLE;
                            idle_ticks = 16'd0;
                        end
                        else
                        begin
                            open_header();
                            r.status = uifr_pkg::ST_READY;
                        end
                    end
                    else
                    begin
                        idle_ticks++;
                    end
                end
                else if (session == SESS_PAYLOAD)
                begin
                    if (idle_ticks >= model_cfg.payload_idle_ms)
                    begin
                        r.status = uifr_pkg::ST_PAYLOAD_TIMEOUT;
                        session = SESS_IDLE;
                        idle_ticks = 16'd0;
                    end
                    else
                    begin
                        idle_ticks++;
                    end
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // Result check first, then the prediction for a transaction accepted here
    always @(posedge clk)
    begin : result_check
        uifr_pkg::result_t got;
        uifr_pkg::result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got.status = uifr_pkg::status_t'(status);
                got.payload_byte = payload_byte;
                got.payload_valid = payload_valid;
                got.payload_last = payload_last;
                if (expected_results.size() == 0)
                begin
                    $error("result with nothing expected: status %0d", status);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, status);
                        mismatch_count++;
                    end
                    if (got.payload_byte !== want.payload_byte)
                    begin
                        $error("payload_byte: expected %0h, actual %0h",
                               want.payload_byte, payload_byte);
                        mismatch_count++;
                    end
                    if (got.payload_valid !== want.payload_valid)
                    begin
                        $error("payload_valid: expected %0d, actual %0d",
                               want.payload_valid, payload_valid);
                        mismatch_count++;
                    end
                    if (got.payload_last !== want.payload_last)
                    begin
                        $error("payload_last: expected %0d, actual %0d",
                               want.payload_last, payload_last);
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                want = predict_frame_result(uifr_pkg::op_t'(operation), rx_byte);
                if (row_typed)
                begin
                    want = '0;
                    want.status = row_want;
                end
                expected_results.push_back(want);
            end
        end
    end

    // Result side back-pressure, with a randomly switched drain pattern
    always @(negedge clk)
    begin
        stall_count++;
        if (stall_count % 160 == 0)
            drain_mode = drain_mode_t'($urandom_range(0, 3));
        case (drain_mode)
            DRAIN_FREE:    out_ready <= 1'b1;
            DRAIN_SPARSE:  out_ready <= ($urandom_range(0, 3) != 0);
            DRAIN_PATTERN: out_ready <= ((stall_count & 7) < 3);
            default:       out_ready <= $urandom_range(0, 1);
        endcase
    end

    task automatic issue_transaction(input uifr_pkg::op_t op, input logic [7:0] b,
                                     input logic typed = 1'b0,
                                     input uifr_pkg::status_t want = uifr_pkg::ST_NONE);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
        end
        in_valid <= 1'b1;
        operation <= op;
        rx_byte <= b;
        row_typed <= typed;
        row_want <= want;
        do
            @(posedge clk);
        while (!in_ready);
        burst_left--;
        if (op != uifr_pkg::OP_NONE)
            items_done++;
    endtask

    task automatic wait_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input uifr_pkg::reg_index_t idx, input logic [31:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            uifr_pkg::REG_HEADER_MAGIC:    model_cfg.header_magic = value;
            uifr_pkg::REG_IMAGE_TYPE:      model_cfg.image_type = value[7:0];
            uifr_pkg::REG_HEADER_IDLE_MS:  model_cfg.header_idle_ms = value[15:0];
            uifr_pkg::REG_PAYLOAD_IDLE_MS: model_cfg.payload_idle_ms = value[15:0];
            uifr_pkg::REG_HEADER_TOTAL_MS: model_cfg.header_total_ms = value;
            default:
            begin
            end
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_frame(input frame_kind_t kind, input bit long_frame);
        logic [7:0]  hdr [16];
        logic [7:0]  body [$];
        logic [31:0] len;
        logic [31:0] sum;
        logic [31:0] word;
        logic [31:0] magic;
        logic [31:0] chunk_end;
        logic [7:0]  type_byte;
        int          r;
        int          i;
        int          cut;
        bit          stray;

        if (kind == FR_NOISE)
        begin
            repeat ($urandom_range(1, 6))
                issue_transaction(uifr_pkg::op_t'($urandom_range(0, 3)),
                                  $urandom_range(0, 255));
            return;
        end

        r = $urandom_range(0, 99);
        if (kind == FR_ZERO_LEN)
            len = 32'd0;
        else if (long_frame || r >= 98)
            len = $urandom_range(250, 262);
        else if (r < 55)
            len = $urandom_range(1, 8);
        else if (r < 85)
            len = $urandom_range(9, 32);
        else
            len = $urandom_range(33, 120);
        if (kind == FR_BAD_IMAGE && len < 32'd4)
            len = 32'd4;
        chunk_end = (len < uifr_pkg::CHUNK_BYTES) ? len : uifr_pkg::CHUNK_BYTES;

        for (i = 0; i < len; i++)
            body.push_back($urandom_range(0, 255));
        if (len >= 32'd4)
        begin
            word = uifr_pkg::IMAGE_WORD_EXPECTED;
            if (kind == FR_BAD_IMAGE)
                word ^= $urandom_range(0, 1) ? (32'd1 << $urandom_range(0, 31))
                                             : ($urandom() | 32'd1);
            for (i = 0; i < 4; i++)
                body[i] = word[8*i +: 8];
        end

        sum = '1;
        for (i = 0; i < len; i++)
            sum = crc_step(sum, body[i]);
        sum = ~sum;
        if (kind == FR_BAD_CRC)
            sum ^= 32'd1 << $urandom_range(0, 31);
        magic = model_cfg.header_magic;
        if (kind == FR_BAD_MAGIC)
            magic ^= 32'd1 << $urandom_range(0, 31);
        type_byte = model_cfg.image_type;
        if (kind == FR_BAD_TYPE)
            type_byte ^= 8'd1 << $urandom_range(0, 7);

        for (i = 0; i < 4; i++)
        begin
            hdr[i] = magic[8*i +: 8];
            hdr[8 + i] = len[8*i +: 8];
            hdr[12 + i] = sum[8*i +: 8];
        end
        hdr[4] = type_byte;
        for (i = 5; i < 8; i++)
            hdr[i] = $urandom_range(0, 255);

        stray = $urandom_range(0, 1);
        if (kind == FR_HEADER_STALL)
            cut = $urandom_range(0, 15);
        else if (kind == FR_PAYLOAD_STALL)
            cut = $urandom_range(0, len - 1);
        else
            cut = $urandom_range(1, 16 + ((len < 8) ? len : 8));

        issue_transaction(uifr_pkg::OP_START, $urandom_range(0, 255));

        // partial frame, then a fresh start mid-session
        if (kind == FR_RESTART)
        begin
            for (i = 0; i < cut; i++)
                issue_transaction(uifr_pkg::OP_BYTE, (i < 16) ? hdr[i] : body[i - 16]);
            issue_transaction(uifr_pkg::OP_START, $urandom_range(0, 255));
        end

        for (i = 0; i < 16; i++)
        begin
            if (kind == FR_HEADER_STALL && i == cut)
            begin
                repeat ($urandom_range(1, 48))
                    issue_transaction(uifr_pkg::OP_TICK, $urandom_range(0, 255));
                return;
            end
            if (stray && $urandom_range(0, 15) == 0)
                issue_transaction(uifr_pkg::OP_TICK, $urandom_range(0, 255));
            issue_transaction(uifr_pkg::OP_BYTE, hdr[i]);
        end
        if (kind == FR_BAD_MAGIC || kind == FR_BAD_TYPE || kind == FR_ZERO_LEN)
            return;

        for (i = 0; i < len; i++)
        begin
            if (kind == FR_PAYLOAD_STALL && i == cut)
            begin
                repeat ($urandom_range(1, (model_cfg.payload_idle_ms < 40) ?
                                           model_cfg.payload_idle_ms + 2 : 40))
                    issue_transaction(uifr_pkg::OP_TICK, $urandom_range(0, 255));
                return;
            end
            if (kind == FR_BAD_IMAGE && i == chunk_end)
                return;
            if (stray && $urandom_range(0, 15) == 0)
                issue_transaction(uifr_pkg::OP_TICK, $urandom_range(0, 255));
            issue_transaction(uifr_pkg::OP_BYTE, body[i]);
        end
    endtask

    initial
    begin
        int          p;
        int          k;
        int          r;
        logic [31:0] mg;
        logic [7:0]  ty;
        logic [15:0] hi;
        logic [15:0] pi;
        logic [31:0] tt;

        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = uifr_pkg::OP_NONE;
        rx_byte = 8'd0;
        cfg_we = 1'b0;
        cfg_index = uifr_pkg::REG_HEADER_MAGIC;
        cfg_wdata = 32'd0;
        row_typed = 1'b0;
        row_want = uifr_pkg::ST_NONE;

        model_cfg.header_magic = 32'd0;
        model_cfg.image_type = 8'd1;
        model_cfg.header_idle_ms = 16'd1000;
        model_cfg.payload_idle_ms = 16'd10000;
        model_cfg.header_total_ms = 32'd30000;
        session = SESS_IDLE;
        hdr_pos = 4'd0;
        seen_magic = 32'd0;
        seen_type = 8'd0;
        want_len = 32'd0;
        want_crc = 32'd0;
        payload_count = 32'd0;
        crc_state = 32'd0;
        first_word = 32'd0;
        idle_ticks = 16'd0;
        header_ticks = 32'd0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (p = 0; p < PHASES; p++)
        begin
            if (p == 0)
            begin
                foreach (DIRECTED_ROWS[k])
                    issue_transaction(DIRECTED_ROWS[k].op, DIRECTED_ROWS[k].data,
                                      DIRECTED_ROWS[k].typed, DIRECTED_ROWS[k].want);
            end
            else
            begin
                wait_until_drained();
                mg = $urandom();
                ty = $urandom_range(0, 255);
                hi = $urandom_range(1, 5);
                pi = $urandom_range(1, 6);
                tt = $urandom_range(1, 40);
                case (p)
                    1:
                    begin
                        hi = 16'd2;
                        pi = 16'd3;
                        tt = 32'd12;
                    end
                    2:
                    begin
                        // zero idle limits: the first tick already times out
                        mg = 32'd0;
                        ty = 8'd0;
                        hi = 16'd0;
                        pi = 16'd0;
                        tt = 32'd1;
                    end
                    3:
                    begin
                        mg = '1;
                        ty = '1;
                        hi = '1;
                        pi = '1;
                        tt = '1;
                    end
                    default:
                    begin
                    end
                endcase
                write_register(uifr_pkg::REG_HEADER_MAGIC, mg);
                write_register(uifr_pkg::REG_IMAGE_TYPE, {24'd0, ty});
                write_register(uifr_pkg::REG_HEADER_IDLE_MS, {16'd0, hi});
                write_register(uifr_pkg::REG_PAYLOAD_IDLE_MS, {16'd0, pi});
                write_register(uifr_pkg::REG_HEADER_TOTAL_MS, tt);
                for (k = FR_GOOD; k <= FR_NOISE; k++)
                    send_frame(frame_kind_t'(k), (p == 1 && k == FR_GOOD));
            end
            while (items_done < ITEM_TARGET * (p + 1) / PHASES)
            begin
                r = $urandom_range(0, 99);
                if (r < 35)
                    send_frame(FR_GOOD, 1'b0);
                else if (r < 45)
                    send_frame(FR_BAD_CRC, 1'b0);
                else if (r < 51)
                    send_frame(FR_BAD_MAGIC, 1'b0);
                else if (r < 57)
                    send_frame(FR_BAD_TYPE, 1'b0);
                else if (r < 61)
                    send_frame(FR_ZERO_LEN, 1'b0);
                else if (r < 69)
                    send_frame(FR_BAD_IMAGE, 1'b0);
                else if (r < 77)
                    send_frame(FR_HEADER_STALL, 1'b0);
                else if (r < 85)
                    send_frame(FR_PAYLOAD_STALL, 1'b0);
                else if (r < 93)
                    send_frame(FR_RESTART, 1'b0);
                else
                    send_frame(FR_NOISE, 1'b0);
            end
        end

        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
